[design/bcf_pkg.sv]
// Package for the branch coverage filter: hash constants, map size default
// and the request bundle passed to the hash unit. No dependencies.
`default_nettype none
package bcf_pkg;

  localparam int unsigned MapSizeDef = 65536;

  localparam logic [31:0] XP1 = 32'h9E3779B1;
  localparam logic [31:0] XP2 = 32'h85EBCA77;
  localparam logic [31:0] XP3 = 32'hC2B2AE3D;
  localparam logic [31:0] XP4 = 32'h27D4EB2F;
  localparam logic [31:0] XP5 = 32'h165667B1;

  localparam logic [31:0] LenLoc  = 32'd9;
  localparam logic [31:0] LenPair = 32'd8;

  typedef struct packed {
    logic        start;
    logic        pair;
    logic [31:0] w0;
    logic [31:0] w1;
    logic [7:0]  b;
  } hash_req_t;

endpackage
`default_nettype wire

[design/branch_coverage_filter_core.sv]
// Top level of the branch coverage filter: control sequencer and the
// coverage memories. Depends on bcf_pkg and bcf_hash.
//
// Usage:
//   Input stream in_*: in_tuser is the operation (0 branch event, 1 session
//   start), in_tdata carries pc and taken. Output stream out_*: one
//   transaction per input, out_tdata[0] = interesting.
//   Items are processed one at a time. A branch event runs the location hash
//   and a hit count read; when the hit count read is zero or a power of two, a
//   context loop then visits each stored visited location (pair hash on the
//   shared multiplier plus a context byte read-modify-write); when the trace
//   changes, an inverse branch hash and a trace read-modify-write follow.
//   A session start runs a clearing pass over the hit counts and visited
//   flags.
//   After reset a clearing pass runs over the hit count, trace, context and
//   visited flag memories; in_tready stays low meanwhile.
//   A finished result sits in an output register; the next input is taken
//   while it waits, and the block holds the following result until
//   out_tready takes the first.
`default_nettype none
module branch_coverage_filter_core #(
  parameter int unsigned MAP_SIZE = bcf_pkg::MapSizeDef
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // pc[63:0], taken[64], zero pad
  input  wire logic [0:0]  in_tuser,   // operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata   // interesting[0], zero pad
);

  localparam int unsigned AW = $clog2(MAP_SIZE);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] MapCount = CW'(MAP_SIZE);
  localparam logic [AW-1:0] ClrLast  = AW'(MAP_SIZE - 1);

  typedef enum logic [13:0] {
    ST_CLEAR = 14'b00000000000001,
    ST_IDLE  = 14'b00000000000010,
    ST_LOC   = 14'b00000000000100,
    ST_RD    = 14'b00000000001000,
    ST_CHK   = 14'b00000000010000,
    ST_VRD   = 14'b00000000100000,
    ST_VGO   = 14'b00000001000000,
    ST_VHASH = 14'b00000010000000,
    ST_CRD   = 14'b00000100000000,
    ST_CWR   = 14'b00001000000000,
    ST_UPD   = 14'b00010000000000,
    ST_INV   = 14'b00100000000000,
    ST_IRD   = 14'b01000000000000,
    ST_IWR   = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [AW-1:0] clr_r;
  logic          clr_all_r;
  logic [63:0]   pc_r;
  logic          tk_r;
  logic [AW-1:0] loc_r;
  logic [AW-1:0] idx_r;
  logic [AW-1:0] inv_idx_r;
  logic [AW-1:0] prev_r;
  logic [CW-1:0] vc_r;
  logic [CW-1:0] k_r;
  logic [AW-1:0] cbyte_r;
  logic [2:0]    cbit_r;
  logic [7:0]    hc_val_r;
  logic [7:0]    gt_val_r;
  logic          flag_val_r;
  logic          fresh_r;
  logic          res_r;
  logic          pend_r;
  logic          out_valid_r;
  logic          out_int_r;

  logic [7:0]    hc_mem [MAP_SIZE];
  logic [7:0]    gt_mem [MAP_SIZE];
  logic [7:0]    ctx_mem [MAP_SIZE];
  logic [AW-1:0] vl_mem [MAP_SIZE];
  logic          fl_mem [MAP_SIZE];

  logic [7:0]    hc_q, gt_q, ctx_q;
  logic [AW-1:0] vl_q;
  logic          fl_q;

  logic [AW-1:0] hc_ra;
  logic          hc_we, gt_we, ctx_we, fl_we, vl_we;
  logic [AW-1:0] hc_wa, gt_wa, ctx_wa, fl_wa;
  logic [7:0]    hc_wd, gt_wd, ctx_wd;

  bcf_pkg::hash_req_t hreq;
  logic               hdone;
  logic [31:0]        hres;

  logic          in_acc;
  logic          pend_ok;
  logic          pend_set;
  logic [7:0]    cnt;
  logic [7:0]    gt_new;
  logic          trace_chg;
  logic          add_visit;
  logic          pow2;
  logic [7:0]    cmask;
  logic          cfree;
  logic [AW-1:0] hloc;

  assign in_tready = (state_r == ST_IDLE) && !pend_r;
  assign in_acc    = in_tvalid && in_tready;
  assign pend_ok   = !out_valid_r || out_tready;
  assign pend_set  = ((state_r == ST_UPD) && !trace_chg) || (state_r == ST_IWR) ||
                     ((state_r == ST_CLEAR) && (clr_r == ClrLast) && !clr_all_r);

  assign cnt       = hc_val_r + 8'd1;
  assign gt_new    = gt_val_r | cnt;
  assign trace_chg = gt_new != gt_val_r;
  assign add_visit = (hc_val_r == 8'd0) && !flag_val_r && (vc_r < MapCount);
  assign pow2      = (hc_q & (hc_q - 8'd1)) == 8'd0;
  assign cmask     = 8'd1 << cbit_r;
  assign cfree     = (ctx_q & cmask) == 8'd0;
  assign hloc      = hres[AW-1:0];

  always_comb begin
    hreq.start = 1'b0;
    hreq.pair  = 1'b0;
    hreq.w0    = in_tdata[31:0];
    hreq.w1    = in_tdata[63:32];
    hreq.b     = {7'd0, in_tdata[64]};
    case (state_r)
      ST_IDLE: hreq.start = in_acc && !in_tuser[0];
      ST_VGO: begin
        hreq.start = 1'b1;
        hreq.pair  = 1'b1;
        hreq.w0    = 32'(vl_q);
        hreq.w1    = 32'(loc_r);
      end
      ST_UPD: begin
        hreq.start = trace_chg;
        hreq.w0    = pc_r[31:0];
        hreq.w1    = pc_r[63:32];
        hreq.b     = {7'd0, ~tk_r};
      end
      default: hreq.start = 1'b0;
    endcase
  end

  bcf_hash u_hash (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (hreq),
    .done   (hdone),
    .result (hres)
  );

  assign hc_ra = (state_r == ST_IRD) ? inv_idx_r : idx_r;

  always_comb begin
    hc_we  = 1'b0;
    gt_we  = 1'b0;
    ctx_we = 1'b0;
    fl_we  = 1'b0;
    vl_we  = 1'b0;
    hc_wa  = idx_r;
    gt_wa  = idx_r;
    ctx_wa = cbyte_r;
    fl_wa  = loc_r;
    hc_wd  = cnt;
    gt_wd  = gt_new;
    ctx_wd = ctx_q | cmask;
    case (state_r)
      ST_CLEAR: begin
        hc_we  = 1'b1;
        fl_we  = 1'b1;
        gt_we  = clr_all_r;
        ctx_we = clr_all_r;
        hc_wa  = clr_r;
        gt_wa  = clr_r;
        ctx_wa = clr_r;
        fl_wa  = clr_r;
        hc_wd  = 8'd0;
        gt_wd  = 8'd0;
        ctx_wd = 8'd0;
      end
      ST_CWR: ctx_we = cfree;
      ST_UPD: begin
        hc_we = 1'b1;
        gt_we = trace_chg;
        fl_we = add_visit;
        vl_we = add_visit;
      end
      ST_IWR: begin
        gt_we = 1'b1;
        gt_wa = inv_idx_r;
        gt_wd = gt_q | (hc_q + 8'd1);
      end
      default: hc_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hc_we) hc_mem[hc_wa] <= hc_wd;
    hc_q <= hc_mem[hc_ra];
  end

  always_ff @(posedge clk) begin
    if (gt_we) gt_mem[gt_wa] <= gt_wd;
    gt_q <= gt_mem[hc_ra];
  end

  always_ff @(posedge clk) begin
    if (ctx_we) ctx_mem[ctx_wa] <= ctx_wd;
    ctx_q <= ctx_mem[cbyte_r];
  end

  always_ff @(posedge clk) begin
    if (fl_we) fl_mem[fl_wa] <= (state_r != ST_CLEAR);
    fl_q <= fl_mem[loc_r];
  end

  always_ff @(posedge clk) begin
    if (vl_we) vl_mem[vc_r[AW-1:0]] <= loc_r;
    vl_q <= vl_mem[k_r[AW-1:0]];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_r == ClrLast) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_acc) state_nxt = in_tuser[0] ? ST_CLEAR : ST_LOC;
      end
      ST_LOC:   if (hdone) state_nxt = ST_RD;
      ST_RD:    state_nxt = ST_CHK;
      ST_CHK:   state_nxt = (pow2 && vc_r != '0) ? ST_VRD : ST_UPD;
      ST_VRD:   state_nxt = ST_VGO;
      ST_VGO:   state_nxt = ST_VHASH;
      ST_VHASH: if (hdone) state_nxt = ST_CRD;
      ST_CRD:   state_nxt = ST_CWR;
      ST_CWR:   state_nxt = (k_r + CW'(1) == vc_r) ? ST_UPD : ST_VRD;
      ST_UPD:   state_nxt = trace_chg ? ST_INV : ST_IDLE;
      ST_INV:   if (hdone) state_nxt = ST_IRD;
      ST_IRD:   state_nxt = ST_IWR;
      ST_IWR:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      clr_all_r   <= 1'b1;
      vc_r        <= '0;
      prev_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pend_r && pend_ok) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      pend_r <= pend_set || (pend_r && !pend_ok);
      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == ClrLast) clr_all_r <= 1'b0;
        end
        ST_IDLE: begin
          if (in_acc && in_tuser[0]) begin
            clr_r  <= '0;
            vc_r   <= '0;
            prev_r <= '0;
          end
        end
        ST_UPD: begin
          if (add_visit) vc_r <= vc_r + CW'(1);
          if (!trace_chg) prev_r <= loc_r;
        end
        ST_IWR:  prev_r <= loc_r;
        default: clr_all_r <= clr_all_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r && pend_ok) out_int_r <= res_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          pc_r    <= in_tdata[63:0];
          tk_r    <= in_tdata[64];
          res_r   <= 1'b0;
          fresh_r <= 1'b0;
        end
      end
      ST_LOC: begin
        if (hdone) begin
          loc_r <= hloc;
          idx_r <= (prev_r >> 1) ^ hloc;
        end
      end
      ST_CHK: begin
        hc_val_r   <= hc_q;
        gt_val_r   <= gt_q;
        flag_val_r <= fl_q;
        k_r        <= '0;
      end
      ST_VHASH: begin
        if (hdone) begin
          cbyte_r <= hres[AW+2:3];
          cbit_r  <= hres[2:0];
        end
      end
      ST_CWR: begin
        if (cfree) fresh_r <= 1'b1;
        k_r <= k_r + CW'(1);
      end
      ST_UPD:  res_r <= trace_chg || fresh_r;
      ST_INV:  if (hdone) inv_idx_r <= (prev_r >> 1) ^ hloc;
      default: res_r <= res_r;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_int_r};

endmodule
`default_nettype wire

[design/bcf_hash.sv]
// Multi-cycle XXH32 (seed 0) unit for 8- or 9-byte messages, one shared
// 32x32 multiplier. Depends on bcf_pkg.
`default_nettype none
module bcf_hash (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bcf_pkg::hash_req_t req,
  output logic                   done,
  output logic [31:0]            result
);

  logic        busy_r;
  logic        done_r;
  logic [3:0]  step_r;
  logic        pair_r;
  logic [31:0] w0_r;
  logic [31:0] w1_r;
  logic [7:0]  b_r;
  logic [31:0] h_r;
  logic [31:0] m_r;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] prod;
  logic [31:0] hsum;

  always_comb begin
    mul_a = h_r;
    mul_b = bcf_pkg::XP4;
    case (step_r)
      4'd0: begin
        mul_a = w0_r;
        mul_b = bcf_pkg::XP3;
      end
      4'd3: begin
        mul_a = w1_r;
        mul_b = bcf_pkg::XP3;
      end
      4'd6: begin
        mul_a = {24'd0, b_r};
        mul_b = bcf_pkg::XP5;
      end
      4'd8:    mul_b = bcf_pkg::XP1;
      4'd10:   mul_b = bcf_pkg::XP2;
      4'd12:   mul_b = bcf_pkg::XP3;
      default: mul_b = bcf_pkg::XP4;
    endcase
  end

  assign prod = mul_a * mul_b;
  assign hsum = h_r + m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 4'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= 4'd0;
      end else if (busy_r) begin
        if (step_r == 4'd13) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else if (step_r == 4'd5 && pair_r) begin
          step_r <= 4'd9;
        end else begin
          step_r <= step_r + 4'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      pair_r <= req.pair;
      w0_r   <= req.w0;
      w1_r   <= req.w1;
      b_r    <= req.b;
      h_r    <= bcf_pkg::XP5 + (req.pair ? bcf_pkg::LenPair : bcf_pkg::LenLoc);
    end else if (busy_r) begin
      case (step_r)
        4'd0, 4'd3, 4'd6: m_r <= prod;
        4'd1, 4'd4:       h_r <= {hsum[14:0], hsum[31:15]};
        4'd7:             h_r <= {hsum[20:0], hsum[31:21]};
        4'd9:             h_r <= h_r ^ (h_r >> 15);
        4'd11:            h_r <= h_r ^ (h_r >> 13);
        4'd13:            h_r <= h_r ^ (h_r >> 16);
        default:          h_r <= prod;
      endcase
    end
  end

  assign done   = done_r;
  assign result = h_r;

endmodule
`default_nettype wire
